/* hdl/msrp_pkg.sv */
// Shared types, codes and the CRC-16 (Modbus) byte update for the
// Modbus sensor reply parser. No dependencies.
package msrp_pkg;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_ARM_ZERO = 2'd1,
      OP_ARM_ANGLE = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_PENDING  = 3'd0,
      ST_REJECT   = 3'd1,
      ST_ZERO_OK  = 3'd2,
      ST_ANGLE_OK = 3'd3,
      ST_NO_ANS   = 3'd4,
      ST_BAD_ANS  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_IDLE  = 2'd0,
      KIND_ZERO  = 2'd1,
      KIND_ANGLE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_DEVICE_ADDRESS = 2'd0,
      REG_FUNCTION_CODE  = 2'd1,
      REG_ABSOLUTE_CODE  = 2'd2,
      REG_RELATIVE_CODE  = 2'd3
   } reg_index_type;

   localparam logic [1:0]  MODE_UNKNOWN  = 2'd0;
   localparam logic [1:0]  MODE_ABSOLUTE = 2'd1;
   localparam logic [1:0]  MODE_RELATIVE = 2'd2;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  ANGLE_COUNT   = 8'h04;
   localparam logic [7:0]  MODE_COUNT    = 8'h02;
   localparam logic [7:0]  MODE_DATA_HI  = 8'h00;
   localparam logic [7:0]  ABS_CRC_LO    = 8'hB8;
   localparam logic [7:0]  ABS_CRC_HI    = 8'h44;
   localparam logic [7:0]  REL_CRC_LO    = 8'h79;
   localparam logic [7:0]  REL_CRC_HI    = 8'h84;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] function_code;
      logic [7:0] absolute_code;
      logic [7:0] relative_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  zero_mode;
      logic [15:0] angle_y;
      logic [15:0] angle_x;
      logic [2:0]  status;
   } rsp_item_type;

   // One byte through the reflected CRC-16, eight shift steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* hdl/msrp_csr.sv */
// Configuration registers of the reply parser.
// Depends on msrp_pkg.
module msrp_csr
   import msrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= 8'd1;
         cfg_ff.function_code  <= 8'd3;
         cfg_ff.absolute_code  <= 8'd0;
         cfg_ff.relative_code  <= 8'd1;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_DEVICE_ADDRESS: cfg_ff.device_address <= csr_wdata;
            REG_FUNCTION_CODE:  cfg_ff.function_code  <= csr_wdata;
            REG_ABSOLUTE_CODE:  cfg_ff.absolute_code  <= csr_wdata;
            REG_RELATIVE_CODE:  cfg_ff.relative_code  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/msrp_parser.sv */
// Reply parser state, single-pass next-state logic: one item per accepted cycle.
// Depends on msrp_pkg.
module msrp_parser
   import msrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_accept,
   input  logic [1:0]   item_op,
   input  logic [7:0]   item_byte,
   input  cfg_type      cfg,
   output rsp_item_type item_rsp
);

   // angle reply steps
   localparam logic [3:0] A_ADDR = 4'd0, A_FUNC = 4'd1, A_COUNT = 4'd2, A_XHI = 4'd3,
                          A_XLO = 4'd4, A_YHI = 4'd5, A_YLO = 4'd6, A_CRCLO = 4'd7,
                          A_CRCHI = 4'd8;
   // zero-mode reply steps
   localparam logic [3:0] M_ADDR = 4'd0, M_FUNC = 4'd1, M_COUNT = 4'd2, M_DHI = 4'd3,
                          M_DLO = 4'd4, M_ABS_LO = 4'd5, M_ABS_HI = 4'd6,
                          M_REL_LO = 4'd7, M_REL_HI = 4'd8;

   kind_type    kind_ff, kind_in;
   logic [3:0]  angle_step_ff, angle_step_in;
   logic [3:0]  mode_step_ff, mode_step_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] part_x_ff, part_x_in;
   logic [15:0] part_y_ff, part_y_in;
   logic [15:0] held_x_ff, held_x_in;
   logic [15:0] held_y_ff, held_y_in;
   logic [1:0]  mode_ff, mode_in;
   logic        bad_ff, bad_in;
   status_type  status;

   logic [15:0] crc_fed;
   logic [15:0] crc_fresh;
   logic [15:0] rx_crc_full;

   assign crc_fed     = crc_feed(crc_ff, item_byte);
   assign crc_fresh   = crc_feed(CRC_INIT, item_byte);
   assign rx_crc_full = {item_byte, rx_crc_ff[7:0]};

   always_comb begin
      kind_in       = kind_ff;
      angle_step_in = angle_step_ff;
      mode_step_in  = mode_step_ff;
      crc_in        = crc_ff;
      rx_crc_in     = rx_crc_ff;
      part_x_in     = part_x_ff;
      part_y_in     = part_y_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      mode_in       = mode_ff;
      bad_in        = bad_ff;
      status        = ST_PENDING;

      case (op_type'(item_op))
         OP_BYTE: begin
            if (kind_ff == KIND_ANGLE) begin
               case (angle_step_ff)
                  A_ADDR: begin
                     if (item_byte == cfg.device_address) begin
                        crc_in = crc_fresh;
                        angle_step_in = A_FUNC;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  A_FUNC: begin
                     if (item_byte == cfg.function_code) begin
                        crc_in = crc_fed;
                        angle_step_in = A_COUNT;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  A_COUNT: begin
                     if (item_byte == ANGLE_COUNT) begin
                        crc_in = crc_fed;
                        part_x_in = 16'h0000;
                        angle_step_in = A_XHI;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  A_XHI: begin
                     part_x_in = {item_byte, 8'h00};
                     crc_in = crc_fed;
                     angle_step_in = A_XLO;
                  end
                  A_XLO: begin
                     part_x_in = {part_x_ff[15:8], item_byte};
                     crc_in = crc_fed;
                     part_y_in = 16'h0000;
                     angle_step_in = A_YHI;
                  end
                  A_YHI: begin
                     part_y_in = {item_byte, 8'h00};
                     crc_in = crc_fed;
                     angle_step_in = A_YLO;
                  end
                  A_YLO: begin
                     part_y_in = {part_y_ff[15:8], item_byte};
                     crc_in = crc_fed;
                     rx_crc_in = 16'h0000;
                     angle_step_in = A_CRCLO;
                  end
                  A_CRCLO: begin
                     rx_crc_in = {8'h00, item_byte};
                     angle_step_in = A_CRCHI;
                  end
                  A_CRCHI: begin
                     rx_crc_in = rx_crc_full;
                     angle_step_in = A_ADDR;
                     if (rx_crc_full == crc_ff) begin
                        held_x_in = part_x_ff;
                        held_y_in = part_y_ff;
                        kind_in = KIND_IDLE;
                        status = ST_ANGLE_OK;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  default: begin
                     angle_step_in = A_ADDR;
                     status = ST_REJECT;
                  end
               endcase
            end else if (kind_ff == KIND_ZERO) begin
               case (mode_step_ff)
                  M_ADDR: begin
                     if (item_byte == cfg.device_address) begin
                        crc_in = crc_fresh;
                        mode_step_in = M_FUNC;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  M_FUNC: begin
                     if (item_byte == cfg.function_code) begin
                        crc_in = crc_fed;
                        mode_step_in = M_COUNT;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  M_COUNT: begin
                     if (item_byte == MODE_COUNT) begin
                        crc_in = crc_fed;
                        mode_step_in = M_DHI;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  M_DHI: begin
                     if (item_byte == MODE_DATA_HI) begin
                        crc_in = crc_fed;
                        mode_step_in = M_DLO;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  M_DLO: begin
                     // equal codes resolve to absolute
                     if (item_byte == cfg.absolute_code) begin
                        crc_in = crc_fed;
                        mode_step_in = M_ABS_LO;
                     end else if (item_byte == cfg.relative_code) begin
                        crc_in = crc_fed;
                        mode_step_in = M_REL_LO;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  M_ABS_LO: begin
                     if (item_byte == ABS_CRC_LO) mode_step_in = M_ABS_HI;
                     else status = ST_REJECT;
                  end
                  M_REL_LO: begin
                     if (item_byte == REL_CRC_LO) mode_step_in = M_REL_HI;
                     else status = ST_REJECT;
                  end
                  M_ABS_HI: begin
                     if (item_byte == ABS_CRC_HI) begin
                        mode_in = MODE_ABSOLUTE;
                        mode_step_in = M_ADDR;
                        kind_in = KIND_IDLE;
                        status = ST_ZERO_OK;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  M_REL_HI: begin
                     if (item_byte == REL_CRC_HI) begin
                        mode_in = MODE_RELATIVE;
                        mode_step_in = M_ADDR;
                        kind_in = KIND_IDLE;
                        status = ST_ZERO_OK;
                     end else begin
                        status = ST_REJECT;
                     end
                  end
                  default: begin
                     mode_step_in = M_ADDR;
                     status = ST_REJECT;
                  end
               endcase
            end
            if (status == ST_REJECT) bad_in = 1'b1;
            else if (status == ST_ANGLE_OK || status == ST_ZERO_OK) bad_in = 1'b0;
         end
         OP_ARM_ZERO:  kind_in = KIND_ZERO;
         OP_ARM_ANGLE: kind_in = KIND_ANGLE;
         OP_TIMEOUT: begin
            if (kind_ff == KIND_ZERO) mode_step_in = M_ADDR;
            else if (kind_ff == KIND_ANGLE) angle_step_in = A_ADDR;
            kind_in = KIND_IDLE;
            bad_in = 1'b0;
            status = bad_ff ? ST_BAD_ANS : ST_NO_ANS;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_IDLE;
         angle_step_ff <= A_ADDR;
         mode_step_ff  <= M_ADDR;
         crc_ff        <= CRC_INIT;
         rx_crc_ff     <= 16'h0000;
         part_x_ff     <= 16'h0000;
         part_y_ff     <= 16'h0000;
         held_x_ff     <= 16'h0000;
         held_y_ff     <= 16'h0000;
         mode_ff       <= MODE_UNKNOWN;
         bad_ff        <= 1'b0;
      end else if (item_accept) begin
         kind_ff       <= kind_in;
         angle_step_ff <= angle_step_in;
         mode_step_ff  <= mode_step_in;
         crc_ff        <= crc_in;
         rx_crc_ff     <= rx_crc_in;
         part_x_ff     <= part_x_in;
         part_y_ff     <= part_y_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         mode_ff       <= mode_in;
         bad_ff        <= bad_in;
      end
   end

   assign item_rsp.status    = status;
   assign item_rsp.angle_x   = held_x_in;
   assign item_rsp.angle_y   = held_y_in;
   assign item_rsp.zero_mode = mode_in;

endmodule

/* hdl/msrp_out_buf.sv */
// Result register with a skid stage so the input side can take one more
// result while the receiver stalls. Depends on msrp_pkg.
module msrp_out_buf
   import msrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_item_type in_item,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_item_type out_item,
   input  logic         out_ready
);

   logic         main_v_ff, skid_v_ff;
   rsp_item_type main_d_ff, skid_d_ff;

   assign in_ready  = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_item  = main_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!main_v_ff || out_ready) begin
         if (skid_v_ff) begin
            main_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            main_v_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_v_ff || out_ready) begin
         main_d_ff <= skid_v_ff ? skid_d_ff : in_item;
      end else if (in_valid) begin
         skid_d_ff <= in_item;
      end
   end

endmodule

/* hdl/modbus_sensor_reply_parser_unit.sv */
// Top level of the Modbus RTU tilt-sensor reply parser.
// Depends on msrp_pkg, msrp_csr, msrp_parser and msrp_out_buf.
//
// Usage:
//   req channel: one transaction per received UART byte or command.
//     req_tuser[1:0] is the op (byte, arm zero-mode reply, arm angle reply,
//     timeout); req_tdata[7:0] is the received byte, looked at only for a byte.
//   rsp channel: exactly one transaction per accepted request, in order,
//     carrying status, the last good X/Y angle words and the known zero mode.
//   csr port: write csr_wdata into register csr_addr (0 device address,
//     1 function code, 2 absolute code, 3 relative code) while idle.
// Result path: the result of a request is registered and appears on rsp in
//   the cycle after its acceptance when the result register is free.
// Throughput: one transaction per cycle while req_tready is high; the parse
//   step (byte compare plus an eight-step CRC-16 byte update) sits between
//   the request edge and the result register.
// Reset: synchronous; clears parser state, restores register defaults and
//   empties the result path; req_tready is high from the first reset edge on.
// Stall: when rsp_tready is low the result holds and one more result goes
//   into the skid stage; req_tready drops only while the skid stage is full.
module modbus_sensor_reply_parser_unit
   import msrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] status, [18:3] angle_x, [34:19] angle_y,
                                    // [36:35] zero_mode, [39:37] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   cfg_type      cfg;
   rsp_item_type item_rsp;
   rsp_item_type out_item;
   logic         req_accept;

   // a request transaction moves on this edge
   assign req_accept = req_tvalid && req_tready;

   msrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msrp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .item_op     (req_tuser),
      .item_byte   (req_tdata),
      .cfg         (cfg),
      .item_rsp    (item_rsp)
   );

   // hold results here; stall only when both result slots are taken
   msrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_item   (item_rsp),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {3'b000, out_item.zero_mode, out_item.angle_y,
                       out_item.angle_x, out_item.status};

endmodule

/* hdl/msrp_checker.sv */
// Port-level checks for the reply parser, bound to the top level.
// Depends on msrp_pkg and modbus_sensor_reply_parser_unit.
module msrp_checker
   import msrp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   logic free_accept;
   assign free_accept = req_tvalid && req_tready && !rsp_tvalid;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_BAD_ANS && rsp_tdata[36:35] != 2'd3)
      else $error("result code out of range");

   a_arm_pending: assert property (@(posedge clock) disable iff (reset)
      free_accept && (req_tuser == OP_ARM_ZERO || req_tuser == OP_ARM_ANGLE)
      |=> rsp_tvalid && rsp_tdata[2:0] == ST_PENDING)
      else $error("arm did not report pending");

   a_timeout_status: assert property (@(posedge clock) disable iff (reset)
      free_accept && req_tuser == OP_TIMEOUT
      |=> rsp_tvalid && (rsp_tdata[2:0] == ST_NO_ANS || rsp_tdata[2:0] == ST_BAD_ANS))
      else $error("timeout did not report an answer status");

endmodule

bind modbus_sensor_reply_parser_unit msrp_checker u_msrp_checker (.*);

/* tb/sv/msrp_reply_checker.sv */
// Scoreboard for the Modbus sensor reply parser: follows register writes and
// accepted requests, predicts every reply and compares it with the rsp stream.
// Depends on msrp_pkg for the channel types, codes and frame constants.
module msrp_reply_checker
   import msrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [2:0] status, [18:3] angle_x, [34:19] angle_y,
                                    // [36:35] zero_mode, [39:37] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          pending,
   output int          errors
);

   cfg_type      regs;
   kind_type     armed_kind;
   logic [3:0]   angle_pos;
   logic [3:0]   mode_pos;
   logic [15:0]  crc_acc;
   logic [15:0]  crc_rcv;
   logic [15:0]  x_acc;
   logic [15:0]  y_acc;
   logic [15:0]  x_good;
   logic [15:0]  y_good;
   logic [1:0]   mode_seen;
   logic         reply_bad;
   rsp_item_type expected_replies[$];

   function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc ^ {8'h00, data};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic status_type reject_byte();
      reply_bad = 1'b1;
      return ST_REJECT;
   endfunction

   // Angle reply: addr, func, count 4, X hi/lo, Y hi/lo, CRC lo/hi.
   function automatic status_type angle_byte(input logic [7:0] b);
      status_type st;
      st = ST_PENDING;
      case (angle_pos)
         4'd0: begin
            if (b != regs.device_address) return reject_byte();
            crc_acc = crc16_byte(CRC_INIT, b);
         end
         4'd1: begin
            if (b != regs.function_code) return reject_byte();
            crc_acc = crc16_byte(crc_acc, b);
         end
         4'd2: begin
            if (b != ANGLE_COUNT) return reject_byte();
            crc_acc = crc16_byte(crc_acc, b);
            x_acc = '0;
         end
         4'd3: begin
            x_acc = {b, 8'h00};
            crc_acc = crc16_byte(crc_acc, b);
         end
         4'd4: begin
            x_acc = x_acc | {8'h00, b};
            crc_acc = crc16_byte(crc_acc, b);
            y_acc = '0;
         end
         4'd5: begin
            y_acc = {b, 8'h00};
            crc_acc = crc16_byte(crc_acc, b);
         end
         4'd6: begin
            y_acc = y_acc | {8'h00, b};
            crc_acc = crc16_byte(crc_acc, b);
            crc_rcv = '0;
         end
         4'd7: crc_rcv = {8'h00, b};
         4'd8: begin
            crc_rcv = crc_rcv | {b, 8'h00};
            angle_pos = '0;
            if (crc_rcv != crc_acc) return reject_byte();
            x_good = x_acc;
            y_good = y_acc;
            reply_bad = 1'b0;
            armed_kind = KIND_IDLE;
            return ST_ANGLE_OK;
         end
         default: begin
            angle_pos = '0;
            return reject_byte();
         end
      endcase
      angle_pos = angle_pos + 4'd1;
      return st;
   endfunction

   // Zero-mode reply: addr, func, count 2, 0x00, code, then a fixed CRC pair.
   function automatic status_type mode_byte(input logic [7:0] b);
      case (mode_pos)
         4'd0: begin
            if (b != regs.device_address) return reject_byte();
            crc_acc = crc16_byte(CRC_INIT, b);
            mode_pos = 4'd1;
         end
         4'd1: begin
            if (b != regs.function_code) return reject_byte();
            crc_acc = crc16_byte(crc_acc, b);
            mode_pos = 4'd2;
         end
         4'd2: begin
            if (b != MODE_COUNT) return reject_byte();
            crc_acc = crc16_byte(crc_acc, b);
            mode_pos = 4'd3;
         end
         4'd3: begin
            if (b != MODE_DATA_HI) return reject_byte();
            crc_acc = crc16_byte(crc_acc, b);
            mode_pos = 4'd4;
         end
         4'd4: begin
            // absolute wins when both codes are equal
            if (b == regs.absolute_code) mode_pos = 4'd5;
            else if (b == regs.relative_code) mode_pos = 4'd7;
            else return reject_byte();
            crc_acc = crc16_byte(crc_acc, b);
         end
         4'd5: begin
            if (b != ABS_CRC_LO) return reject_byte();
            mode_pos = 4'd6;
         end
         4'd6: begin
            if (b != ABS_CRC_HI) return reject_byte();
            mode_seen = MODE_ABSOLUTE;
            mode_pos = '0;
            reply_bad = 1'b0;
            armed_kind = KIND_IDLE;
            return ST_ZERO_OK;
         end
         4'd7: begin
            if (b != REL_CRC_LO) return reject_byte();
            mode_pos = 4'd8;
         end
         4'd8: begin
            if (b != REL_CRC_HI) return reject_byte();
            mode_seen = MODE_RELATIVE;
            mode_pos = '0;
            reply_bad = 1'b0;
            armed_kind = KIND_IDLE;
            return ST_ZERO_OK;
         end
         default: begin
            mode_pos = '0;
            return reject_byte();
         end
      endcase
      return ST_PENDING;
   endfunction

   function automatic rsp_item_type predict_reply(input op_type op, input logic [7:0] b);
      rsp_item_type r;
      r = '0;
      r.status = ST_PENDING;
      case (op)
         OP_BYTE: begin
            if (armed_kind == KIND_ZERO) r.status = mode_byte(b);
            else if (armed_kind == KIND_ANGLE) r.status = angle_byte(b);
         end
         OP_ARM_ZERO:  armed_kind = KIND_ZERO;
         OP_ARM_ANGLE: armed_kind = KIND_ANGLE;
         default: begin
            if (armed_kind == KIND_ZERO) mode_pos = '0;
            else if (armed_kind == KIND_ANGLE) angle_pos = '0;
            armed_kind = KIND_IDLE;
            r.status = reply_bad ? ST_BAD_ANS : ST_NO_ANS;
            reply_bad = 1'b0;
         end
      endcase
      r.angle_x = x_good;
      r.angle_y = y_good;
      r.zero_mode = mode_seen;
      return r;
   endfunction

   task automatic report(input string what, input logic [39:0] want, input logic [39:0] got);
      errors++;
      $display("%0t: reply mismatch on %s, expected %0h, got %0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         regs       = {8'h01, 8'h03, 8'h00, 8'h01};
         armed_kind = KIND_IDLE;
         angle_pos  = '0;
         mode_pos   = '0;
         crc_acc    = CRC_INIT;
         crc_rcv    = '0;
         x_acc      = '0;
         y_acc      = '0;
         x_good     = '0;
         y_good     = '0;
         mode_seen  = MODE_UNKNOWN;
         reply_bad  = 1'b0;
         errors     = 0;
         expected_replies.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_DEVICE_ADDRESS: regs.device_address = csr_wdata;
               REG_FUNCTION_CODE:  regs.function_code  = csr_wdata;
               REG_ABSOLUTE_CODE:  regs.absolute_code  = csr_wdata;
               default:            regs.relative_code  = csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(predict_reply(op_type'(req_tuser), req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[36:0];
            if (expected_replies.size() == 0) begin
               report("unexpected reply", '0, rsp_tdata);
            end else begin
               want = expected_replies.pop_front();
               if (got.status != want.status)
                  report("status", 40'(want.status), 40'(got.status));
               if (got.angle_x != want.angle_x)
                  report("angle_x", 40'(want.angle_x), 40'(got.angle_x));
               if (got.angle_y != want.angle_y)
                  report("angle_y", 40'(want.angle_y), 40'(got.angle_y));
               if (got.zero_mode != want.zero_mode)
                  report("zero_mode", 40'(want.zero_mode), 40'(got.zero_mode));
               if (rsp_tdata[39:37] != 3'b000)
                  report("padding", '0, 40'(rsp_tdata[39:37]));
            end
         end
      end
      pending = expected_replies.size();
   end

endmodule

/* tb/sv/tb.sv */
// Testbench top for modbus_sensor_reply_parser_unit: builds sensor replies,
// writes the registers, throttles the reply side and prints the verdict.
// Depends on msrp_pkg, msrp_reply_checker and the block under test.
module tb
   import msrp_pkg::*;
();

   // Far above the slowest legal run: ~1300 transactions, bursty sender,
   // receiver mostly stalled in its slowest pattern.
   localparam int RUN_LIMIT       = 400000;
   localparam int ANGLE_FRAME_LEN = 9;
   localparam int MODE_FRAME_LEN  = 7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic [1:0]  req_tuser  = 2'b00;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [2:0] status, [18:3] angle_x, [34:19] angle_y,
                                      // [36:35] zero_mode, [39:37] zero
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = 2'b00;
   logic [7:0]  csr_wdata  = 8'h00;

   int      pending;
   int      errors;
   int      cycles = 0;
   int      burst_left = 0;
   int      items_sent = 0;
   cfg_type regs_now;   // register values the replies are built against

   always #5 clock = ~clock;

   modbus_sensor_reply_parser_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   msrp_reply_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .errors     (errors)
   );

   // Reply-side back-pressure. cycles[10:9] picks one of four stall patterns:
   // always ready, mostly ready, ready one cycle in three, mostly stalled.
   // The same counter ends a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      case (cycles[10:9])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_tready <= (cycles % 3 == 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
      if (cycles == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Send one transaction. Between bursts drop valid for a random gap;
   // inside a burst hold valid high from one transaction to the next.
   task automatic send_item(input op_type op, input logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Hold the request side until every predicted reply has come back. The
   // first edge lets the checker book the last accepted transaction.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Write all four registers on back-to-back edges; call only when drained.
   task automatic program_regs(input cfg_type c);
      csr_we    <= 1'b1;
      csr_addr  <= REG_DEVICE_ADDRESS;
      csr_wdata <= c.device_address;
      @(posedge clock);
      csr_addr  <= REG_FUNCTION_CODE;
      csr_wdata <= c.function_code;
      @(posedge clock);
      csr_addr  <= REG_ABSOLUTE_CODE;
      csr_wdata <= c.absolute_code;
      @(posedge clock);
      csr_addr  <= REG_RELATIVE_CODE;
      csr_wdata <= c.relative_code;
      @(posedge clock);
      csr_we    <= 1'b0;
      regs_now = c;
   endtask

   // Arm for an angle reply and send its first len bytes. A bad_pos of zero
   // or more flips one bit there: a header byte gets rejected, a data or
   // CRC byte makes the CRC check fail on the last byte.
   task automatic send_angle_reply(input logic [15:0] x, input logic [15:0] y,
                                   input int bad_pos, input int len);
      logic [7:0]  frame [ANGLE_FRAME_LEN];
      logic [15:0] crc;
      frame[0] = regs_now.device_address;
      frame[1] = regs_now.function_code;
      frame[2] = ANGLE_COUNT;
      frame[3] = x[15:8];
      frame[4] = x[7:0];
      frame[5] = y[15:8];
      frame[6] = y[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 7; i++) crc = crc_feed(crc, frame[i]);
      frame[7] = crc[7:0];
      frame[8] = crc[15:8];
      if (bad_pos >= 0) frame[bad_pos] ^= 8'd1 << $urandom_range(0, 7);
      send_item(OP_ARM_ANGLE, 8'($urandom_range(0, 255)));
      for (int i = 0; i < len; i++) send_item(OP_BYTE, frame[i]);
   endtask

   // Arm for a zero-mode reply carrying code; the trailer is the fixed pair
   // that matches the code, or random bytes when the code matches neither.
   task automatic send_mode_reply(input logic [7:0] code, input int bad_pos, input int len);
      logic [7:0] frame [MODE_FRAME_LEN];
      frame[0] = regs_now.device_address;
      frame[1] = regs_now.function_code;
      frame[2] = MODE_COUNT;
      frame[3] = MODE_DATA_HI;
      frame[4] = code;
      if (code == regs_now.absolute_code) begin
         frame[5] = ABS_CRC_LO;
         frame[6] = ABS_CRC_HI;
      end else if (code == regs_now.relative_code) begin
         frame[5] = REL_CRC_LO;
         frame[6] = REL_CRC_HI;
      end else begin
         frame[5] = 8'($urandom_range(0, 255));
         frame[6] = 8'($urandom_range(0, 255));
      end
      if (bad_pos >= 0) frame[bad_pos] ^= 8'd1 << $urandom_range(0, 7);
      send_item(OP_ARM_ZERO, 8'($urandom_range(0, 255)));
      for (int i = 0; i < len; i++) send_item(OP_BYTE, frame[i]);
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly whole replies with random content; the rest corrupted or cut
   // short replies, lone timeouts and raw noise on every op.
   task automatic random_traffic(input int count);
      int         stop_at;
      int         pick;
      int         bad_pos;
      int         len;
      logic [7:0] code;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ANGLE_FRAME_LEN - 1) : -1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, ANGLE_FRAME_LEN - 1)
                                              : ANGLE_FRAME_LEN;
            send_angle_reply(pick_angle(), pick_angle(), bad_pos, len);
         end else if (pick < 70) begin
            bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MODE_FRAME_LEN - 1) : -1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MODE_FRAME_LEN - 1)
                                              : MODE_FRAME_LEN;
            case ($urandom_range(0, 9))
               0:       code = 8'($urandom_range(0, 255));
               1, 2, 3, 4: code = regs_now.absolute_code;
               default: code = regs_now.relative_code;
            endcase
            send_mode_reply(code, bad_pos, len);
         end else if (pick < 80) begin
            bad_pos = -1;
            len = 0;
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
         end else begin
            bad_pos = -1;
            len = 0;
            repeat ($urandom_range(1, 4))
               send_item(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
         // Time out most broken replies so the next reply starts clean.
         if ((bad_pos >= 0 || (len != 0 && len != ANGLE_FRAME_LEN && pick < 40) ||
              (len != 0 && len != MODE_FRAME_LEN && pick >= 40 && pick < 70)) &&
             $urandom_range(0, 4) != 0) begin
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
         end
         // Now and then let the reply side catch up completely.
         if ($urandom_range(0, 59) == 0) drain();
      end
   endtask

   initial begin : stimulus
      cfg_type setting;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      regs_now = {8'h01, 8'h03, 8'h00, 8'h01};

      // Directed: timeout while idle, byte while idle, an angle reply with
      // extreme words, a rejected address followed by a bad-answer timeout,
      // then a relative zero-mode reply.
      send_item(OP_TIMEOUT, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_angle_reply(16'hFFFF, 16'h0000, -1, ANGLE_FRAME_LEN);
      send_item(OP_ARM_ZERO, 8'hFF);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_TIMEOUT, 8'hFF);
      send_mode_reply(regs_now.relative_code, -1, MODE_FRAME_LEN);

      random_traffic(200);

      // Register settings: all-zero address and function with the codes at
      // opposite extremes, all-ones address with equal codes, then random.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       setting = {8'h00, 8'h00, 8'hFF, 8'h00};
            1:       setting = {8'hFF, 8'hFF, 8'h5A, 8'h5A};
            default: setting = $urandom();
         endcase
         drain();
         program_regs(setting);
         random_traffic(210);
      end

      drain();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
